[sv/cubic_bezier_point_eval_top_defines.svh]
// assertion macros used by the curve evaluator datapath (cbz_pipe)
// expects signals named clk and arst_n in the module that uses them
`ifndef CUBIC_BEZIER_POINT_EVAL_TOP_DEFINES_SVH
`define CUBIC_BEZIER_POINT_EVAL_TOP_DEFINES_SVH

// same-cycle implication
`define CBZ_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define CBZ_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[sv/cbz_pkg.sv]
// widths, constants and types for the cubic bezier point evaluator
// no dependencies
package cbz_pkg;

	localparam int STEP_BITS  = 11;
	localparam int COORD_BITS = 10;
	localparam int NUM_CTRL   = 4;

	// register map: 8 registers at byte addresses 4*i
	localparam int IDX_W  = $clog2(2 * NUM_CTRL);
	localparam int ADDR_W = IDX_W + 2;
	localparam int DATA_W = 32;

	// u = N - i reaches N, so one extra bit; two more bits for the 3x terms
	localparam int OP_W   = STEP_BITS + 3;
	localparam int SQ_W   = 2 * (STEP_BITS + 1);
	localparam int MUL_W  = SQ_W + OP_W;
	// each bernstein weight is at most N^3
	localparam int W_W    = 3 * STEP_BITS + 1;
	localparam int PROD_W = W_W + COORD_BITS;
	localparam int WSUM_W = W_W + 2;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic [NUM_CTRL-1:0][COORD_BITS-1:0] x;
		logic [NUM_CTRL-1:0][COORD_BITS-1:0] y;
	} cbz_points_t;

endpackage

[sv/cbz_pipe.sv]
// five-stage datapath: operands, squares, bernstein weights, products, sums
// depends on cbz_pkg and cubic_bezier_point_eval_top_defines.svh
`include "cubic_bezier_point_eval_top_defines.svh"

module cbz_pipe import cbz_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [STEP_BITS-1:0] step_index,
	input  cbz_points_t          points,
	output logic                 out_valid,
	input  logic                 out_stall,
	output coord_t               point_x,
	output coord_t               point_y
);

	logic adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [OP_W-1:0] i_s1, u_s1, i3_s1, u3_s1;
	logic [OP_W-1:0] i_s2, u_s2, i3_s2, u3_s2;
	logic [SQ_W-1:0] ii_s2, uu_s2;
	logic [NUM_CTRL-1:0][W_W-1:0] w_s3;
	logic [NUM_CTRL-1:0][PROD_W-1:0] px_s4, py_s4;
	coord_t x_s5, y_s5;

	logic [OP_W-1:0] i_in, u_in;
	logic [MUL_W-1:0] m0, m1, m2, m3;
	logic [PROD_W-1:0] sx, sy;

	// whole pipe freezes only when the output transaction is held back
	assign adv      = !(v_s5 && out_stall);
	assign in_stall = !adv;

	assign i_in = OP_W'(step_index);
	assign u_in = (OP_W'(1) << STEP_BITS) - i_in;

	assign m0 = MUL_W'(uu_s2) * MUL_W'(u_s2);
	assign m1 = MUL_W'(uu_s2) * MUL_W'(i3_s2);
	assign m2 = MUL_W'(ii_s2) * MUL_W'(u3_s2);
	assign m3 = MUL_W'(ii_s2) * MUL_W'(i_s2);

	assign sx = px_s4[0] + px_s4[1] + px_s4[2] + px_s4[3];
	assign sy = py_s4[0] + py_s4[1] + py_s4[2] + py_s4[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			i_s1  <= i_in;
			u_s1  <= u_in;
			i3_s1 <= i_in + (i_in << 1);
			u3_s1 <= u_in + (u_in << 1);

			i_s2  <= i_s1;
			u_s2  <= u_s1;
			i3_s2 <= i3_s1;
			u3_s2 <= u3_s1;
			ii_s2 <= SQ_W'(i_s1) * SQ_W'(i_s1);
			uu_s2 <= SQ_W'(u_s1) * SQ_W'(u_s1);

			w_s3[0] <= m0[W_W-1:0];
			w_s3[1] <= m1[W_W-1:0];
			w_s3[2] <= m2[W_W-1:0];
			w_s3[3] <= m3[W_W-1:0];

			// the user must keep the control points stable while items are in flight; the block does not enforce this
			for (int k = 0; k < NUM_CTRL; k++) begin
				px_s4[k] <= PROD_W'(w_s3[k]) * PROD_W'(points.x[k]);
				py_s4[k] <= PROD_W'(w_s3[k]) * PROD_W'(points.y[k]);
			end

			// divide by N^3: weights sum to N^3, so the quotient fits a coordinate
			x_s5 <= sx[3*STEP_BITS +: COORD_BITS];
			y_s5 <= sy[3*STEP_BITS +: COORD_BITS];
		end
	end

	assign out_valid = v_s5;
	assign point_x   = x_s5;
	assign point_y   = y_s5;

	`CBZ_ASSERT_NEXT(a_enter, in_valid && !in_stall, v_s1, "accepted transaction lost at entry")
	`CBZ_ASSERT_NOW(a_freeze, out_valid && out_stall, in_stall, "input taken while output held")
	`CBZ_ASSERT_NEXT(a_reach, v_s4 && !in_stall, out_valid, "transaction lost before output")
	`CBZ_ASSERT_NOW(a_part, v_s3,
		(WSUM_W'(w_s3[0]) + WSUM_W'(w_s3[1]) + WSUM_W'(w_s3[2]) + WSUM_W'(w_s3[3]))
		== (WSUM_W'(1) << (3 * STEP_BITS)), "bernstein weights do not sum to N^3")

endmodule

[sv/cubic_bezier_point_eval_top.sv]
// top level of the cubic bezier point evaluator: control point registers and datapath
// depends on cbz_pkg and cbz_pipe
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------
//   step in  | in_valid / in_stall    | step_index
//   point out| out_valid / out_stall  | point_x, point_y
//   config   | psel penable pwrite    | paddr, pwdata, prdata
//
// one step accepted every cycle while in_stall is low; each result passes in order through
// the five stages: operands, squares, weight multipliers, point multipliers, sums
// an output stall while out_valid is high freezes all stages together; in_stall follows it in the same cycle
// reset clears the valid bits and sets every control point to zero
module cubic_bezier_point_eval_top import cbz_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [STEP_BITS-1:0] step_index,
	output logic                 out_valid,
	input  logic                 out_stall,
	output coord_t               point_x,
	output coord_t               point_y,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready
);

	cbz_points_t points_q;

	logic [IDX_W-1:0] idx;
	logic             bank_y;
	logic [IDX_W-2:0] slot;
	logic             wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:2];
	assign bank_y = idx[IDX_W-1];
	assign slot   = idx[IDX_W-2:0];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= '0;
		end else if (wr_en) begin
			if (bank_y) begin
				points_q.y[slot] <= pwdata[COORD_BITS-1:0];
			end else begin
				points_q.x[slot] <= pwdata[COORD_BITS-1:0];
			end
		end
	end

	always_comb begin
		if (bank_y) begin
			prdata = DATA_W'(points_q.y[slot]);
		end else begin
			prdata = DATA_W'(points_q.x[slot]);
		end
	end

	cbz_pipe u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.step_index (step_index),
		.points     (points_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.point_x    (point_x),
		.point_y    (point_y)
	);

endmodule
